>>> src/mem_ap_burst_chunk_planner_top_assert.svh
// Assertion macros used by the chunk planner back sequencer.
`ifndef MEM_AP_BURST_CHUNK_PLANNER_TOP_ASSERT_SVH
`define MEM_AP_BURST_CHUNK_PLANNER_TOP_ASSERT_SVH

// Checks that a property holds at every clock edge outside reset.
`define MABCP_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mabcp check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define MABCP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mabcp check failed");

`endif

>>> src/mabcp_pkg.sv
package mabcp_pkg;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 16;
    localparam int BEATS_W = 11;

    typedef struct packed {
        logic               dir;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
        logic               err;
    } req_t;

    typedef struct packed {
        logic               dir;
        logic [ADDR_W-1:0]  addr;
        logic [1:0]         size;
        logic [BEATS_W-1:0] beats;
        logic               status;
        logic               last;
    } out_t;

endpackage

>>> src/mabcp_front.sv
module mabcp_front #(
    parameter int MAX_TRANSFER_BYTES = 32768
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_dir,
    input  logic [31:0]         in_addr,
    input  logic [15:0]         in_count,
    output logic                q_valid,
    input  logic                q_ready,
    output mabcp_pkg::req_t     q_data
);
    import mabcp_pkg::*;

    localparam logic [COUNT_W:0] MAX_BYTES = (COUNT_W+1)'(MAX_TRANSFER_BYTES);

    logic link_up_reg;
    logic valid_reg;
    logic valid_next;
    req_t hold_reg;
    req_t hold_next;
    logic accept;

    assign in_ready = !valid_reg || q_ready;
    assign accept   = in_valid && in_ready;
    assign q_valid  = valid_reg;
    assign q_data   = hold_reg;

    always_comb
    begin
        hold_next.dir   = in_dir;
        hold_next.addr  = in_addr;
        hold_next.count = in_count;
        hold_next.err   = !link_up_reg || (in_count == '0) ||
                          ({1'b0, in_count} > MAX_BYTES);
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_up_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                link_up_reg <= cfg_wdata;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= hold_next;
        end
    end

endmodule

>>> src/mabcp_queue.sv
module mabcp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mabcp_pkg::req_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output mabcp_pkg::req_t out_data
);
    import mabcp_pkg::*;

    req_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

>>> src/mabcp_back.sv
module mabcp_back #(
    parameter int WRAP_BOUNDARY_BYTES = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  mabcp_pkg::req_t q_data,
    output logic            out_valid,
    input  logic            out_ready,
    output mabcp_pkg::out_t out_data
);
    import mabcp_pkg::*;

    `include "mem_ap_burst_chunk_planner_top_assert.svh"

    localparam int            BW        = $clog2(WRAP_BOUNDARY_BYTES);
    localparam logic [BW:0]   WRAP_SIZE = (BW+1)'(WRAP_BOUNDARY_BYTES);

    logic               busy_reg;
    logic               busy_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               dir_reg;
    logic               err_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  addr_next;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] rem_next;
    out_t               out_reg;
    out_t               out_next;

    logic               advance;
    logic               load;
    logic [BW:0]        to_bound;
    logic               rem_fits;
    logic [BW:0]        chunk;
    logic [1:0]         low_bits;
    logic [BW:0]        beats_full;

    assign q_ready   = !busy_reg;
    assign load      = q_valid && q_ready;
    assign advance   = busy_reg && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        to_bound = WRAP_SIZE - {1'b0, addr_reg[BW-1:0]};
        rem_fits = rem_reg <= COUNT_W'(to_bound);
        chunk    = rem_fits ? rem_reg[BW:0] : to_bound;
        low_bits = addr_reg[1:0] | chunk[1:0];

        out_next.dir    = dir_reg;
        out_next.addr   = addr_reg;
        out_next.status = err_reg;
        if (err_reg)
        begin
            out_next.size = SIZE_BYTE;
            beats_full    = '0;
            out_next.last = 1'b1;
        end
        else
        begin
            if (low_bits == 2'b00)
            begin
                out_next.size = SIZE_WORD;
                beats_full    = chunk >> 2;
            end
            else if (!low_bits[0])
            begin
                out_next.size = SIZE_HALF;
                beats_full    = chunk >> 1;
            end
            else
            begin
                out_next.size = SIZE_BYTE;
                beats_full    = chunk;
            end
            out_next.last = rem_fits;
        end
        out_next.beats = beats_full[BEATS_W-1:0];

        addr_next = addr_reg + ADDR_W'(chunk);
        rem_next  = rem_reg - COUNT_W'(chunk);

        if (load)
        begin
            busy_next = 1'b1;
        end
        else if (advance && out_next.last)
        begin
            busy_next = 1'b0;
        end
        else
        begin
            busy_next = busy_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dir_reg  <= q_data.dir;
            err_reg  <= q_data.err;
            addr_reg <= q_data.addr;
            rem_reg  <= q_data.count;
        end
        else if (advance)
        begin
            addr_reg <= addr_next;
            rem_reg  <= rem_next;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    `MABCP_ASSERT_NEXT(a_load_sets_busy, clk, rst_n, load, busy_reg)
    `MABCP_ASSERT(a_rem_nonzero, clk, rst_n, !busy_reg || err_reg || (rem_reg != '0))
    `MABCP_ASSERT_NEXT(a_last_ends_run, clk, rst_n, advance && out_next.last,
                       !busy_reg && out_valid_reg && out_reg.last)

endmodule

>>> src/mem_ap_burst_chunk_planner_top.sv
// Channel    | Direction | Contents
// s_axis     | in        | tdata: start_address, byte_count; tuser: req_type
// m_axis     | out       | tdata: chunk_address, beat_size, beat_count;
//            |           | tuser: direction, status; tlast: last
// cfg        | in        | cfg_we, cfg_wdata: link_up
//
// A request is registered in the front stage and then waits in a two-entry queue.
// The back sequencer first loads a request and then emits one chunk per cycle while
// its output is not stalled; it takes the next request after the last chunk.
// An invalid request gives a single error result from the sequencer.
// Reset clears link_up and all control state; the block takes requests right after it.
// A stalled output holds the sequencer; the front accepts until the queue is full.
module mem_ap_burst_chunk_planner_top #(
    parameter int MAX_TRANSFER_BYTES  = 32768,
    parameter int WRAP_BOUNDARY_BYTES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // start_address [31:0], byte_count [47:32]
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // chunk_address [31:0], beat_size [33:32],
                                        // beat_count [44:34], zero fill [47:45]
    output logic [1:0]  m_axis_tuser,   // direction [0], status [1]
    output logic        m_axis_tlast
);
    import mabcp_pkg::*;

    logic fq_valid;
    logic fq_ready;
    req_t fq_data;
    logic qb_valid;
    logic qb_ready;
    req_t qb_data;
    out_t res;

    mabcp_front #(
        .MAX_TRANSFER_BYTES(MAX_TRANSFER_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_dir   (s_axis_tuser),
        .in_addr  (s_axis_tdata[31:0]),
        .in_count (s_axis_tdata[47:32]),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    mabcp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (fq_valid),
        .in_ready (fq_ready),
        .in_data  (fq_data),
        .out_valid(qb_valid),
        .out_ready(qb_ready),
        .out_data (qb_data)
    );

    mabcp_back #(
        .WRAP_BOUNDARY_BYTES(WRAP_BOUNDARY_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_data   (qb_data),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (res)
    );

    assign m_axis_tdata = {3'b000, res.beats, res.size, res.addr};
    assign m_axis_tuser = {res.status, res.dir};
    assign m_axis_tlast = res.last;

endmodule

>>> tb/mem_ap_burst_chunk_planner_top_test.sv
`timescale 1ns / 100ps

module mem_ap_burst_chunk_planner_top_test;

    import mabcp_pkg::*;

    localparam int MAX_BYTES    = 32768;
    localparam int WRAP_BYTES   = 1024;
    localparam int MAX_CHUNKS   = 33;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic         dir;
        logic [31:0]  addr;
        logic [15:0]  count;
    } xfer_req_t;

    typedef enum logic [1:0] {
        IDLE_SEND_LIGHT,
        IDLE_RECV_LIGHT,
        IDLE_NONE
    } idle_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    xfer_req_t   pending_q[$];
    out_t        chunk_q[$];
    xfer_req_t   cur_req;
    xfer_req_t   nxt_req;
    logic        link_up_mdl = 1'b0;
    int unsigned send_idle_pct = 19;
    int unsigned recv_idle_pct = 70;
    int unsigned queued_count = 0;
    int unsigned accepted_count = 0;
    int unsigned rejected_count = 0;
    int unsigned chunk_count = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    mem_ap_burst_chunk_planner_top #(
        .MAX_TRANSFER_BYTES  (MAX_BYTES),
        .WRAP_BOUNDARY_BYTES (WRAP_BYTES)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    task automatic plan_chunks(input xfer_req_t r);
        logic [31:0] addr;
        logic [31:0] both;
        int unsigned remaining;
        int unsigned to_bnd;
        int unsigned chunk;
        int unsigned beats;
        int          n;
        out_t        e;
        addr = r.addr;
        remaining = {16'd0, r.count};
        n = 0;
        if (!link_up_mdl || remaining == 0 || remaining > MAX_BYTES)
        begin
            e.dir = r.dir;
            e.addr = r.addr;
            e.size = SIZE_BYTE;
            e.beats = '0;
            e.status = 1'b1;
            e.last = 1'b1;
            chunk_q.push_back(e);
            rejected_count++;
        end
        else
        begin
            while (remaining > 0 && n < MAX_CHUNKS)
            begin
                to_bnd = WRAP_BYTES - (addr & (WRAP_BYTES - 1));
                chunk = (remaining < to_bnd) ? remaining : to_bnd;
                both = addr | chunk;
                if (both[1:0] == 2'b00)
                begin
                    e.size = SIZE_WORD;
                    beats = chunk >> 2;
                end
                else if (both[0] == 1'b0)
                begin
                    e.size = SIZE_HALF;
                    beats = chunk >> 1;
                end
                else
                begin
                    e.size = SIZE_BYTE;
                    beats = chunk;
                end
                remaining = remaining - chunk;
                e.dir = r.dir;
                e.addr = addr;
                e.beats = beats[BEATS_W-1:0];
                e.status = 1'b0;
                e.last = (remaining == 0 || n == MAX_CHUNKS - 1);
                chunk_q.push_back(e);
                n++;
                addr = addr + chunk;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
            error_count++;
        end
    endtask

    task automatic add_req(input logic dir, input logic [31:0] addr, input logic [15:0] count);
        xfer_req_t r;
        r.dir = dir;
        r.addr = addr;
        r.count = count;
        pending_q.push_back(r);
        queued_count++;
    endtask

    task automatic add_random_reqs(input int num);
        logic [31:0] addr;
        logic [15:0] count;
        int unsigned sel;
        for (int i = 0; i < num; i++)
        begin
            addr = $urandom();
            if ($urandom_range(99) < 20)
            begin
                addr[9:0] = 10'h3FF - 10'($urandom_range(7));
            end
            sel = $urandom_range(99);
            if (sel < 8)
            begin
                count = $urandom_range(1) ? 16'd0 : 16'(32769 + $urandom_range(32766));
            end
            else
            begin
                if (sel < 12)
                begin
                    count = 16'($urandom_range(32768, 16384));
                end
                else if (sel < 40)
                begin
                    count = 16'($urandom_range(2048, 1));
                end
                else
                begin
                    count = 16'($urandom_range(64, 1));
                end
                if ($urandom_range(1) && count != 16'd32768)
                begin
                    count[1:0] = 2'b00;
                    if (count == 16'd0)
                    begin
                        count = 16'd4;
                    end
                end
            end
            add_req(1'($urandom_range(1)), addr, count);
        end
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SEND_LIGHT:
            begin
                send_idle_pct = 19;
                recv_idle_pct = 70;
            end
            IDLE_RECV_LIGHT:
            begin
                send_idle_pct = 70;
                recv_idle_pct = 19;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    task automatic wait_drained();
        while (accepted_count != queued_count || chunk_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_link(input logic value);
        wait_drained();
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_wdata <= 1'b0;
        link_up_mdl = value;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                plan_chunks(cur_req);
                accepted_count++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt_req = pending_q.pop_front();
                    cur_req <= nxt_req;
                    s_axis_tdata <= {nxt_req.count, nxt_req.addr};
                    s_axis_tuser <= nxt_req.dir;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (chunk_q.size() == 0)
                begin
                    $error("Unexpected chunk descriptor: tdata %0h, tuser %0h, tlast %0b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    error_count++;
                end
                else
                begin
                    out_t e;
                    e = chunk_q.pop_front();
                    check_field("direction", 32'(e.dir), 32'(m_axis_tuser[0]));
                    check_field("chunk_address", e.addr, m_axis_tdata[31:0]);
                    check_field("beat_size", 32'(e.size), 32'(m_axis_tdata[33:32]));
                    check_field("beat_count", 32'(e.beats), 32'(m_axis_tdata[44:34]));
                    check_field("status", 32'(e.status), 32'(m_axis_tuser[1]));
                    check_field("last", 32'(e.last), 32'(m_axis_tlast));
                    chunk_count++;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        set_idle(IDLE_SEND_LIGHT);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Link down rejects every request, valid or not.
        add_req(1'b0, 32'h0000_1000, 16'd16);
        add_req(1'b1, 32'hFFFF_FFFF, 16'd32768);
        add_req(1'b0, 32'h0000_0000, 16'd0);

        write_link(1'b1);
        add_req(1'b0, 32'h1234_5678, 16'd0);
        add_req(1'b1, 32'h0000_0000, 16'd32769);
        add_req(1'b0, 32'hFFFF_FFFF, 16'hFFFF);
        add_req(1'b0, 32'h0000_0000, 16'd32768);
        add_req(1'b1, 32'h0000_0001, 16'd32768);
        add_req(1'b1, 32'hFFFF_FFFF, 16'd32768);
        add_req(1'b0, 32'h0000_0003, 16'd1);
        add_req(1'b1, 32'h0000_0002, 16'd2);
        add_req(1'b0, 32'h0000_0000, 16'd3);
        add_req(1'b1, 32'h0000_0000, 16'd4);
        add_req(1'b0, 32'h0000_0002, 16'd6);
        add_req(1'b1, 32'hFFFF_FFFE, 16'd8);
        add_req(1'b0, 32'hFFFF_FC00, 16'd1024);
        add_req(1'b1, 32'h0000_03FF, 16'd2);
        add_req(1'b0, 32'h0000_03FE, 16'd1024);
        add_req(1'b1, 32'hAAAA_AAAA, 16'd1025);
        add_req(1'b0, 32'h5555_5554, 16'd4096);

        add_random_reqs(40);

        write_link(1'b0);
        add_random_reqs(12);

        write_link(1'b1);
        set_idle(IDLE_RECV_LIGHT);
        add_random_reqs(50);

        wait_drained();
        set_idle(IDLE_NONE);
        add_random_reqs(40);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (chunk_q.size() != 0)
        begin
            $error("%0d chunk descriptors never arrived", chunk_q.size());
            error_count++;
        end

        $display("Covered %0d requests (%0d rejected) and %0d chunk descriptors,",
                 accepted_count, rejected_count, chunk_count);
        $display("with the link down and up and under three idle patterns on both sides.");
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
